FILE: rtl/core/pdg_pkg.sv
package pdg_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam int POS_W    = 24;
    localparam int INV_W    = 16;
    localparam int PROD_W   = POS_W + INV_W;
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = 24;
    localparam int VALUE_W  = 32;
    localparam int CIDX_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOSIT_WEIGHT = 2'd2;

    localparam logic [INV_W-1:0]    INV_CELL_RESET = 16'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 24'd65536;

    typedef enum logic {
        OP_DEPOSIT    = 1'b0,
        OP_READ_CLEAR = 1'b1
    } op_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t  op;
        logic oob;
    } cmd_ctl_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } back_state_t;

endpackage

FILE: rtl/core/particle_density_deposit_grid_top.sv
// an accepted input passes the stage-one registers, the command queue, the command and grid read
// registers, then the result register; the back takes one command at a time: command pop with
// grid read, grid write-back, then the result transfer before the back takes the next command
// front and back are split by a 4-entry command queue; the result sits in one output register
// reset: asynchronous, active low; config registers return to defaults
// after reset the grid is zeroed by a pass over all GRID_WIDTH*GRID_HEIGHT cells, full stays high
module particle_density_deposit_grid_top #(
    parameter int GRID_WIDTH  = pdg_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = pdg_pkg::GRID_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              operation,
    input  logic [pdg_pkg::POS_W-1:0]         pos_x,
    input  logic [pdg_pkg::POS_W-1:0]         pos_y,
    input  logic [pdg_pkg::CIDX_W-1:0]        cell_index,
    output logic                              empty,
    input  logic                              pop,
    output logic [pdg_pkg::VALUE_W-1:0]       cell_value,
    output logic                              out_of_grid,
    input  logic                              cfg_write,
    input  logic [pdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CELL_W = $clog2(GRID_WIDTH * GRID_HEIGHT);
    localparam int DEPTH  = pdg_pkg::QUEUE_DEPTH;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CTL_W  = $bits(pdg_pkg::cmd_ctl_t);
    localparam int QD_W   = CTL_W + CELL_W;

    logic [pdg_pkg::INV_W-1:0]    inv_x_reg, inv_x_next;
    logic [pdg_pkg::INV_W-1:0]    inv_y_reg, inv_y_next;
    logic [pdg_pkg::WEIGHT_W-1:0] weight_reg, weight_next;

    logic                 clearing;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_empty;
    logic [CNT_W-1:0]     q_count;
    pdg_pkg::cmd_ctl_t    f_ctl;
    logic [CELL_W-1:0]    f_idx;
    logic [QD_W-1:0]      q_head;
    pdg_pkg::cmd_ctl_t    b_ctl;
    logic [CELL_W-1:0]    b_idx;

    always_comb
    begin
        inv_x_next  = inv_x_reg;
        inv_y_next  = inv_y_reg;
        weight_next = weight_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pdg_pkg::CFG_INV_CELL_X:     inv_x_next  = cfg_data[pdg_pkg::INV_W-1:0];
                pdg_pkg::CFG_INV_CELL_Y:     inv_y_next  = cfg_data[pdg_pkg::INV_W-1:0];
                pdg_pkg::CFG_DEPOSIT_WEIGHT: weight_next = cfg_data[pdg_pkg::WEIGHT_W-1:0];
                default:                     weight_next = weight_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg  <= pdg_pkg::INV_CELL_RESET;
            inv_y_reg  <= pdg_pkg::INV_CELL_RESET;
            weight_reg <= pdg_pkg::WEIGHT_RESET;
        end
        else
        begin
            inv_x_reg  <= inv_x_next;
            inv_y_reg  <= inv_y_next;
            weight_reg <= weight_next;
        end
    end

    pdg_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .DEPTH       (DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cell_index (cell_index),
        .inv_cell_x (inv_x_reg),
        .inv_cell_y (inv_y_reg),
        .clearing   (clearing),
        .q_count    (q_count),
        .q_push     (q_push),
        .q_ctl      (f_ctl),
        .q_idx      (f_idx)
    );

    pdg_queue #(
        .DATA_W (QD_W),
        .DEPTH  (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_ctl, f_idx}),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .count     (q_count)
    );

    assign b_ctl = pdg_pkg::cmd_ctl_t'(q_head[QD_W-1:CELL_W]);
    assign b_idx = q_head[CELL_W-1:0];

    pdg_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .deposit_weight (weight_reg),
        .q_empty        (q_empty),
        .q_ctl          (b_ctl),
        .q_idx          (b_idx),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .empty          (empty),
        .pop            (pop),
        .cell_value     (cell_value),
        .out_of_grid    (out_of_grid)
    );

endmodule

FILE: rtl/core/pdg_queue.sv
module pdg_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = pdg_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [DATA_W-1:0]            push_data,
    input  logic                         pop,
    output logic [DATA_W-1:0]            head_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign empty     = (count_reg == '0);
    assign count     = count_reg;

    // the front reserves room before it accepts, so the queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH) || pop))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count lost track");

endmodule

FILE: rtl/core/pdg_front.sv
module pdg_front #(
    parameter int GRID_WIDTH  = pdg_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = pdg_pkg::GRID_HEIGHT_DEF,
    parameter int DEPTH       = pdg_pkg::QUEUE_DEPTH
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          push,
    output logic                                          full,
    input  logic                                          operation,
    input  logic [pdg_pkg::POS_W-1:0]                     pos_x,
    input  logic [pdg_pkg::POS_W-1:0]                     pos_y,
    input  logic [pdg_pkg::CIDX_W-1:0]                    cell_index,
    input  logic [pdg_pkg::INV_W-1:0]                     inv_cell_x,
    input  logic [pdg_pkg::INV_W-1:0]                     inv_cell_y,
    input  logic                                          clearing,
    input  logic [$clog2(DEPTH+1)-1:0]                    q_count,
    output logic                                          q_push,
    output pdg_pkg::cmd_ctl_t                             q_ctl,
    output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]     q_idx
);

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int XW         = $clog2(GRID_WIDTH);
    localparam int YW         = $clog2(GRID_HEIGHT);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int PROD_W     = pdg_pkg::PROD_W;
    localparam int POS_W      = pdg_pkg::POS_W;

    logic                         s1_valid_reg, s1_valid_next;
    pdg_pkg::op_t                 s1_op_reg;
    logic [PROD_W-1:0]            prod_x_reg;
    logic [PROD_W-1:0]            prod_y_reg;
    logic [pdg_pkg::CIDX_W-1:0]   s1_cell_reg;

    logic                         accept;
    logic [CNT_W:0]               used;
    logic [PROD_W-1:0]            rnd_x;
    logic [PROD_W-1:0]            rnd_y;
    logic [POS_W-1:0]             nx;
    logic [POS_W-1:0]             ny;
    logic                         dep_oob;
    logic                         rd_oob;
    logic [CELL_W-1:0]            dep_idx;
    logic [31:0]                  cell_wide;

    // an item in stage one already owns a queue slot
    assign used   = {1'b0, q_count} + (CNT_W + 1)'(s1_valid_reg);
    assign full   = clearing || (used >= (CNT_W + 1)'(DEPTH));
    assign accept = push && !full;
    assign s1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= pdg_pkg::op_t'(operation);
            prod_x_reg  <= PROD_W'(pos_x) * PROD_W'(inv_cell_x);
            prod_y_reg  <= PROD_W'(pos_y) * PROD_W'(inv_cell_y);
            s1_cell_reg <= cell_index;
        end
    end

    // round half up to the nearest grid point
    assign rnd_x = prod_x_reg + PROD_W'(32'h8000);
    assign rnd_y = prod_y_reg + PROD_W'(32'h8000);
    assign nx    = rnd_x[PROD_W-1:pdg_pkg::FRAC_W];
    assign ny    = rnd_y[PROD_W-1:pdg_pkg::FRAC_W];

    assign dep_oob = (nx >= POS_W'(GRID_WIDTH)) || (ny >= POS_W'(GRID_HEIGHT));
    assign dep_idx = CELL_W'(ny[YW-1:0]) * CELL_W'(GRID_WIDTH) + CELL_W'(nx[XW-1:0]);

    assign cell_wide = 32'(s1_cell_reg);
    assign rd_oob    = (cell_wide >= 32'(CELL_COUNT));

    always_comb
    begin
        q_push     = s1_valid_reg;
        q_ctl.op   = s1_op_reg;
        q_ctl.oob  = 1'b0;
        q_idx      = '0;
        case (s1_op_reg)
            pdg_pkg::OP_DEPOSIT:
            begin
                q_ctl.oob = dep_oob;
                q_idx     = dep_idx;
            end
            pdg_pkg::OP_READ_CLEAR:
            begin
                q_ctl.oob = rd_oob;
                q_idx     = cell_wide[CELL_W-1:0];
            end
            default:
            begin
                q_ctl.oob = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/pdg_back.sv
module pdg_back #(
    parameter int GRID_WIDTH  = pdg_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = pdg_pkg::GRID_HEIGHT_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [pdg_pkg::WEIGHT_W-1:0]                  deposit_weight,
    input  logic                                          q_empty,
    input  pdg_pkg::cmd_ctl_t                             q_ctl,
    input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]     q_idx,
    output logic                                          q_pop,
    output logic                                          clearing,
    output logic                                          empty,
    input  logic                                          pop,
    output logic [pdg_pkg::VALUE_W-1:0]                   cell_value,
    output logic                                          out_of_grid
);

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int VALUE_W    = pdg_pkg::VALUE_W;

    pdg_pkg::back_state_t state_reg, state_next;
    logic [CELL_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                 res_valid_reg, res_valid_next;
    logic [VALUE_W-1:0]   res_value_reg;
    logic                 res_oob_reg;

    pdg_pkg::cmd_ctl_t    cmd_ctl_reg;
    logic [CELL_W-1:0]    cmd_idx_reg;
    logic [VALUE_W-1:0]   rd_data_reg;

    logic [VALUE_W-1:0]   grid_mem [CELL_COUNT];

    logic                 mem_we;
    logic [CELL_W-1:0]    mem_waddr;
    logic [VALUE_W-1:0]   mem_wdata;
    logic                 res_load;
    logic [VALUE_W-1:0]   res_value;
    logic [VALUE_W:0]     sum;
    logic [VALUE_W-1:0]   sat_sum;

    assign sum     = {1'b0, rd_data_reg} + (VALUE_W + 1)'(deposit_weight);
    assign sat_sum = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdg_pkg::BK_CLEAR:
            begin
                if (clr_cnt_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    state_next = pdg_pkg::BK_IDLE;
                end
            end
            pdg_pkg::BK_IDLE:
            begin
                if (!q_empty && !res_valid_reg)
                begin
                    state_next = pdg_pkg::BK_UPDATE;
                end
            end
            pdg_pkg::BK_UPDATE:
            begin
                state_next = pdg_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = pdg_pkg::BK_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = 1'b0;
        clearing  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cmd_idx_reg;
        mem_wdata = '0;
        res_load  = 1'b0;
        res_value = '0;
        case (state_reg)
            pdg_pkg::BK_CLEAR:
            begin
                clearing  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            pdg_pkg::BK_IDLE:
            begin
                q_pop = !q_empty && !res_valid_reg;
            end
            pdg_pkg::BK_UPDATE:
            begin
                res_load = 1'b1;
                mem_we   = !cmd_ctl_reg.oob;
                if (cmd_ctl_reg.op == pdg_pkg::OP_READ_CLEAR)
                begin
                    mem_wdata = '0;
                    res_value = cmd_ctl_reg.oob ? '0 : rd_data_reg;
                end
                else
                begin
                    mem_wdata = sat_sum;
                end
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    assign clr_cnt_next   = (state_reg == pdg_pkg::BK_CLEAR) ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign res_valid_next = res_load ? 1'b1 : (pop ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdg_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_ctl_reg <= q_ctl;
            cmd_idx_reg <= q_idx;
        end
        if (res_load)
        begin
            res_value_reg <= res_value;
            res_oob_reg   <= cmd_ctl_reg.oob;
        end
    end

    // grid memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rd_data_reg <= grid_mem[q_idx];
        end
    end

    assign empty       = !res_valid_reg;
    assign cell_value  = res_value_reg;
    assign out_of_grid = res_oob_reg;

    a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !res_valid_reg)
        else $error("result overwritten before transfer");

    a_update_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == pdg_pkg::BK_UPDATE))
        else $error("command popped without update");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdg_pkg::BK_CLEAR) |-> (!q_pop && !res_valid_reg))
        else $error("command taken during clearing pass");

endmodule

FILE: tb/density_grid_checker.sv
module density_grid_checker #(
    parameter int GRID_WIDTH  = pdg_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = pdg_pkg::GRID_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic                              operation,
    input  logic [pdg_pkg::POS_W-1:0]         pos_x,
    input  logic [pdg_pkg::POS_W-1:0]         pos_y,
    input  logic [pdg_pkg::CIDX_W-1:0]        cell_index,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [pdg_pkg::VALUE_W-1:0]       cell_value,
    input  logic                              out_of_grid,
    input  logic                              cfg_write,
    input  logic [pdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                outstanding,
    output int                                fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pdg_pkg::*;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               oob;
    } cell_result_t;

    logic [VALUE_W-1:0]  density_cells [CELL_COUNT];
    logic [INV_W-1:0]    inv_x_q;
    logic [INV_W-1:0]    inv_y_q;
    logic [WEIGHT_W-1:0] weight_q;
    cell_result_t        awaited_results [$];
    cell_result_t        due_result;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // scale by the reciprocal cell size, round half up
    function automatic logic [POS_W:0] grid_point(input logic [POS_W-1:0] pos,
                                                  input logic [INV_W-1:0] inv);
        logic [PROD_W-1:0] prod;
        prod = pos * inv;
        return (POS_W + 1)'((prod + PROD_W'(32'h8000)) >> FRAC_W);
    endfunction

    function automatic cell_result_t apply_item(input op_t op,
                                                input logic [POS_W-1:0] px,
                                                input logic [POS_W-1:0] py,
                                                input logic [CIDX_W-1:0] ci);
        cell_result_t     res;
        logic [POS_W:0]   nx;
        logic [POS_W:0]   ny;
        int unsigned      idx;
        logic [VALUE_W:0] sum;
        res = '0;
        if (op == OP_DEPOSIT)
        begin
            nx = grid_point(px, inv_x_q);
            ny = grid_point(py, inv_y_q);
            if (nx >= GRID_WIDTH || ny >= GRID_HEIGHT)
            begin
                res.oob = 1'b1;
            end
            else
            begin
                idx = ny * GRID_WIDTH + nx;
                sum = density_cells[idx] + weight_q;
                // accumulators stick at all ones instead of wrapping
                density_cells[idx] = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
            end
        end
        else
        begin
            if (ci >= CELL_COUNT)
            begin
                res.oob = 1'b1;
            end
            else
            begin
                res.value = density_cells[ci];
                density_cells[ci] = '0;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                density_cells[i] = '0;
            end
            inv_x_q  = INV_CELL_RESET;
            inv_y_q  = INV_CELL_RESET;
            weight_q = WEIGHT_RESET;
            awaited_results.delete();
            outstanding = 0;
        end
        else
        begin
            // result side first so a same-edge input transfer never pairs with it
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: cell_value %h out_of_grid %b",
                           cell_value, out_of_grid);
                    fail_count++;
                end
                else
                begin
                    due_result = awaited_results.pop_front();
                    if (cell_value !== due_result.value)
                    begin
                        $error("cell_value mismatch: expected %h, actual %h",
                               due_result.value, cell_value);
                        fail_count++;
                    end
                    if (out_of_grid !== due_result.oob)
                    begin
                        $error("out_of_grid mismatch: expected %b, actual %b",
                               due_result.oob, out_of_grid);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                awaited_results.push_back(apply_item(op_t'(operation), pos_x, pos_y,
                                                     cell_index));
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_INV_CELL_X:     inv_x_q  = cfg_data[INV_W-1:0];
                    CFG_INV_CELL_Y:     inv_y_q  = cfg_data[INV_W-1:0];
                    CFG_DEPOSIT_WEIGHT: weight_q = cfg_data[WEIGHT_W-1:0];
                    default:            ;
                endcase
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

FILE: tb/particle_density_deposit_grid_top_tb.sv
module particle_density_deposit_grid_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdg_pkg::*;

    localparam int GRID_W      = GRID_WIDTH_DEF;
    localparam int GRID_H      = GRID_HEIGHT_DEF;
    localparam int CELLS       = GRID_W * GRID_H;
    // covers the clearing pass after reset plus generous slack
    localparam int STALL_LIMIT = 20000;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push;
    logic                  full;
    logic                  operation;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [CIDX_W-1:0]     cell_index;
    logic                  empty;
    logic                  pop;
    logic [VALUE_W-1:0]    cell_value;
    logic                  out_of_grid;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int               outstanding;
    int               fail_count;
    int               idle_cycles = 0;
    int               push_gap_pct = 0;
    int               pop_stall_pct = 0;
    logic [INV_W-1:0] stim_inv_x = INV_CELL_RESET;
    logic [INV_W-1:0] stim_inv_y = INV_CELL_RESET;
    int               recent_cells [$];

    always #5 clk = ~clk;

    particle_density_deposit_grid_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .cell_index  (cell_index),
        .empty       (empty),
        .pop         (pop),
        .cell_value  (cell_value),
        .out_of_grid (out_of_grid),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    density_grid_checker #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .cell_index  (cell_index),
        .empty       (empty),
        .pop         (pop),
        .cell_value  (cell_value),
        .out_of_grid (out_of_grid),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: pop held low in random stall bursts
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop_stall_pct != 0 && $urandom_range(0, 99) < pop_stall_pct)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 7)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_item(input op_t op, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py, input logic [CIDX_W-1:0] ci);
        if (push_gap_pct != 0 && $urandom_range(0, 99) < push_gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        operation  <= op;
        pos_x      <= px;
        pos_y      <= py;
        cell_index <= ci;
        push       <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_grid_config(input logic [INV_W-1:0] ix, input logic [INV_W-1:0] iy,
                                   input logic [WEIGHT_W-1:0] w);
        // upper data bits are don't-care for the reciprocal registers
        cfg_write <= 1'b1;
        cfg_index <= CFG_INV_CELL_X;
        cfg_data  <= {8'($urandom), ix};
        @(posedge clk);
        cfg_index <= CFG_INV_CELL_Y;
        cfg_data  <= {8'($urandom), iy};
        @(posedge clk);
        cfg_index <= CFG_DEPOSIT_WEIGHT;
        cfg_data  <= w;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        stim_inv_x = ix;
        stim_inv_y = iy;
        recent_cells.delete();
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 2))
            0:       push_gap_pct = 0;
            1:       push_gap_pct = 15;
            default: push_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
            0:       pop_stall_pct = 0;
            1:       pop_stall_pct = 15;
            default: pop_stall_pct = 40;
        endcase
    endtask

    // position that rounds to grid point g along an axis
    function automatic logic [POS_W-1:0] aim_at(input int g, input logic [INV_W-1:0] inv);
        if (inv == 0)
        begin
            return POS_W'($urandom);
        end
        return POS_W'((g * 65536) / inv + $urandom_range(0, 32767 / inv));
    endfunction

    task automatic random_traffic(input int count, input int read_pct, input int noise_pct,
                                  input bit spare_origin);
        op_t               op;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [CIDX_W-1:0] ci;
        int                gx;
        int                gy;
        repeat (count)
        begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
            ci = CIDX_W'($urandom);
            if ($urandom_range(0, 99) < read_pct)
            begin
                op = OP_READ_CLEAR;
                if (spare_origin)
                begin
                    ci = CIDX_W'($urandom_range(1, CELLS - 1));
                end
                else if (recent_cells.size() != 0 && $urandom_range(0, 2) != 0)
                begin
                    ci = CIDX_W'(recent_cells[$urandom_range(0, recent_cells.size() - 1)]);
                end
            end
            else
            begin
                op = OP_DEPOSIT;
                if ($urandom_range(0, 99) >= noise_pct)
                begin
                    gx = ($urandom_range(0, 15) == 0) ? $urandom_range(GRID_W, GRID_W + 6)
                                                      : $urandom_range(0, GRID_W - 1);
                    gy = ($urandom_range(0, 15) == 0) ? $urandom_range(GRID_H, GRID_H + 6)
                                                      : $urandom_range(0, GRID_H - 1);
                    px = aim_at(gx, stim_inv_x);
                    py = aim_at(gy, stim_inv_y);
                    if (gx < GRID_W && gy < GRID_H && stim_inv_x != 0 && stim_inv_y != 0)
                    begin
                        recent_cells.push_back(gy * GRID_W + gx);
                        if (recent_cells.size() > 32)
                        begin
                            void'(recent_cells.pop_front());
                        end
                    end
                end
            end
            send_item(op, px, py, ci);
        end
    endtask

    task automatic random_phase(input int count);
        logic [INV_W-1:0]    ix;
        logic [INV_W-1:0]    iy;
        logic [WEIGHT_W-1:0] w;
        ix = ($urandom_range(0, 3) == 0) ? INV_W'($urandom_range(1, 65535))
                                         : INV_W'($urandom_range(32, 2048));
        iy = ($urandom_range(0, 3) == 0) ? INV_W'($urandom_range(1, 65535))
                                         : INV_W'($urandom_range(32, 2048));
        w  = ($urandom_range(0, 1) == 0) ? WEIGHT_W'($urandom)
                                         : WEIGHT_W'($urandom_range(1, 4096));
        set_grid_config(ix, iy, w);
        random_traffic(count, 30, 10, 1'b0);
        wait_idle();
    endtask

    initial
    begin
        push       = 1'b0;
        operation  = OP_DEPOSIT;
        pos_x      = '0;
        pos_y      = '0;
        cell_index = '0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_INV_CELL_X;
        cfg_data   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset configuration: unit cells, unit weight
        push_gap_pct  = 20;
        pop_stall_pct = 20;
        send_item(OP_DEPOSIT, 24'd0, 24'd0, 12'd0);
        send_item(OP_DEPOSIT, 24'd127, 24'd127, 12'hFFF);
        send_item(OP_DEPOSIT, 24'd128, 24'd128, 12'd0);
        send_item(OP_DEPOSIT, 24'(63 * 256 + 127), 24'(63 * 256 + 127), 12'd0);
        send_item(OP_DEPOSIT, 24'(63 * 256), 24'd0, 12'd0);
        // first half step past the last grid point on each axis
        send_item(OP_DEPOSIT, 24'(63 * 256 + 128), 24'd0, 12'd0);
        send_item(OP_DEPOSIT, 24'd0, 24'(63 * 256 + 128), 12'd0);
        send_item(OP_DEPOSIT, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF);
        send_item(OP_DEPOSIT, 24'hFFFFFF, 24'd0, 12'd0);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'd0);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'd0);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'd65);
        send_item(OP_READ_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'hFFF);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'd63);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'(63 * 64));
        send_item(OP_DEPOSIT, 24'd128, 24'd0, 12'd0);
        send_item(OP_DEPOSIT, 24'd255, 24'd0, 12'd0);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'd1);
        wait_idle();

        pick_idling();
        set_grid_config(INV_W'($urandom_range(64, 1024)), INV_W'($urandom_range(64, 1024)),
                        WEIGHT_W'($urandom_range(1, 65535)));
        random_traffic(200, 30, 15, 1'b0);
        wait_idle();

        // widest reciprocal, zero weight
        pick_idling();
        set_grid_config(16'hFFFF, 16'hFFFF, '0);
        random_traffic(100, 30, 15, 1'b0);
        wait_idle();

        // smallest nonzero reciprocal
        pick_idling();
        set_grid_config(16'd1, 16'd1, WEIGHT_W'($urandom));
        random_traffic(150, 30, 15, 1'b0);
        wait_idle();

        // zero reciprocal folds everything onto the origin cell until it saturates
        pick_idling();
        set_grid_config('0, '0, '1);
        random_traffic(300, 10, 20, 1'b1);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'd0);
        send_item(OP_READ_CLEAR, 24'd0, 24'd0, 12'd0);
        wait_idle();

        pick_idling();
        set_grid_config('0, INV_W'($urandom_range(64, 1024)),
                        WEIGHT_W'($urandom_range(1, 65535)));
        random_traffic(100, 30, 15, 1'b0);
        wait_idle();

        pick_idling();
        random_phase(200);
        pick_idling();
        random_phase(200);

        // closing stretch with no idling on either side
        push_gap_pct  = 0;
        pop_stall_pct = 0;
        random_phase(180);

        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
